// File: rtl/itf_pkg.sv
`timescale 1ns / 1ps
// itf_pkg: shared types, ASCII codes and the digit lookup for the integer
// to text formatter. No dependencies.
package itf_pkg;

  localparam int MAX_FIELD   = 64;   // cap on characters per request
  localparam int NUM_NIBBLES = 24;   // digit buffer depth, one nibble per digit
  localparam int DIG_W       = NUM_NIBBLES * 4;
  localparam int MAG_W       = 64;

  // radix selector codes; the unused code behaves as hex
  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_CALC,
    ST_EMIT
  } state_t;

  // "0123456789ABCDEF" / "0123456789abcdef"
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'h0, d};
    end else if (upper) begin
      c = 8'h41 + {4'h0, d - 4'd10};
    end else begin
      c = 8'h61 + {4'h0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// File: rtl/integer_to_text_formatter.sv
`timescale 1ns / 1ps
// integer_to_text_formatter: printf-style integer conversion, one character
// per output transfer. Depends on itf_pkg.

// One request in, a run of ASCII characters out, the final one with tlast.
// A request is taken only while the block is idle. Decimal values go through
// a bit-serial binary-to-BCD converter (shift-and-add-3), one magnitude bit
// per cycle; octal and hex digits are wired straight into the digit buffer.
// Leading zero digits are then shifted out one per cycle (at most 23 of
// them, so that at least one digit stays), the ST_CALC state works out the
// padding, sign, prefix and zero runs, and the characters leave at one per
// cycle while the sink keeps tready high. Each request gives at most 64
// characters, and one that produces none gives no output transfer at all.
module integer_to_text_formatter
  import itf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  // [63:0] magnitude, [64] is_negative, [66:65] radix_code, [67] upper_case,
  // [68] alternate_form, [69] left_justify, [70] force_plus, [71] space_sign,
  // [72] zero_pad, [79:73] field_width, [86:80] min_digits, [87] unused
  input  logic [87:0] s_tdata,
  // character channel
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] character
  output logic [7:0]  m_tdata,
  output logic        m_tlast   // last_char
);

  // ---------------------------------------------------------------------
  // request fields
  // ---------------------------------------------------------------------
  logic [MAG_W-1:0] in_mag;
  logic             in_neg, in_upper, in_alt, in_left, in_plus, in_space, in_zpad;
  logic [1:0]       in_radix;
  logic [6:0]       in_width, in_prec;

  assign in_mag   = s_tdata[63:0];
  assign in_neg   = s_tdata[64];
  assign in_radix = s_tdata[66:65];
  assign in_upper = s_tdata[67];
  assign in_alt   = s_tdata[68];
  assign in_left  = s_tdata[69];
  assign in_plus  = s_tdata[70];
  assign in_space = s_tdata[71];
  assign in_zpad  = s_tdata[72];
  assign in_width = s_tdata[79:73];
  assign in_prec  = s_tdata[86:80];

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  state_t           state, state_next;
  logic [MAG_W-1:0] mag;        // magnitude shift register for BCD conversion
  logic [DIG_W-1:0] dig;        // digit buffer, most significant digit at top
  logic [5:0]       bit_cnt;
  logic [4:0]       ndig;       // digits held / digits still to send
  logic             neg, upper, alt, left, plus, space, zpad, is_zero;
  logic [1:0]       radix;
  logic [6:0]       width, prec;
  logic [6:0]       lpad_cnt;   // leading spaces still to send
  logic [6:0]       zero_cnt;   // zero fill still to send
  logic             sign_pend, pfx0_pend, pfxx_pend;
  logic [6:0]       rem;        // characters still to send, capped

  // ---------------------------------------------------------------------
  // digit buffer load for octal / hex, and shift-and-add-3 step
  // ---------------------------------------------------------------------
  logic [DIG_W-1:0] oct_load, hex_load, dabble;
  logic [65:0]      mag66;

  assign mag66    = {2'b00, in_mag};
  assign hex_load = {{(DIG_W-MAG_W){1'b0}}, in_mag};

  always_comb begin
    oct_load = '0;
    for (int i = 0; i < 22; i++) begin
      oct_load[i*4 +: 4] = {1'b0, mag66[i*3 +: 3]};
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_NIBBLES; i++) begin
      dabble[i*4 +: 4] = (dig[i*4 +: 4] >= 4'd5) ? dig[i*4 +: 4] + 4'd3 : dig[i*4 +: 4];
    end
  end

  // ---------------------------------------------------------------------
  // sizing: runs of zeros and padding, worked out in the ST_CALC cycle
  // ---------------------------------------------------------------------
  logic       prec_given, sign_c, pfx_c;
  logic [4:0] ndig_e;
  logic [8:0] ndig9, prec9, width9, npre9, body9, zeros9, total9, pad9, len9;
  logic [6:0] rem_c;

  always_comb begin
    prec_given = !prec[6];
    sign_c     = neg | plus | space;
    pfx_c      = alt && (radix != RADIX_OCT) && (radix != RADIX_DEC) && !is_zero;
    ndig_e     = (prec == 7'd0 && is_zero) ? 5'd0 : ndig;
    ndig9      = {4'd0, ndig_e};
    prec9      = {3'd0, prec[5:0]};
    width9     = {2'd0, width};
    npre9      = {8'd0, sign_c} + (pfx_c ? 9'd2 : 9'd0);
    body9      = npre9 + ndig9;

    zeros9 = '0;
    if (prec_given && prec9 > ndig9) begin
      zeros9 = prec9 - ndig9;
    end
    // octal alternate form: make sure the first digit written is 0
    if (alt && radix == RADIX_OCT && zeros9 == 9'd0 && (!is_zero || ndig_e == 5'd0)) begin
      zeros9 = 9'd1;
    end
    if (zpad && !left && !prec_given && width9 > body9) begin
      zeros9 = width9 - body9;
    end

    total9 = body9 + zeros9;
    pad9   = (width9 > total9) ? width9 - total9 : 9'd0;
    len9   = total9 + pad9;
    rem_c  = (len9 > 9'(MAX_FIELD)) ? 7'(MAX_FIELD) : len9[6:0];
  end

  // ---------------------------------------------------------------------
  // character picked for the next output transfer
  // ---------------------------------------------------------------------
  logic [7:0] char_c;
  logic       sel_lpad, sel_sign, sel_pfx0, sel_pfxx, sel_zero, sel_dig;

  always_comb begin
    sel_lpad = lpad_cnt != 7'd0;
    sel_sign = !sel_lpad && sign_pend;
    sel_pfx0 = !sel_lpad && !sign_pend && pfx0_pend;
    sel_pfxx = !sel_lpad && !sign_pend && !pfx0_pend && pfxx_pend;
    sel_zero = !sel_lpad && !sign_pend && !pfx0_pend && !pfxx_pend && zero_cnt != 7'd0;
    sel_dig  = !sel_lpad && !sign_pend && !pfx0_pend && !pfxx_pend && zero_cnt == 7'd0
               && ndig != 5'd0;
    if (sel_lpad) begin
      char_c = CH_SPACE;
    end else if (sel_sign) begin
      char_c = neg ? CH_MINUS : (plus ? CH_PLUS : CH_SPACE);
    end else if (sel_pfx0 || sel_zero) begin
      char_c = CH_ZERO;
    end else if (sel_pfxx) begin
      char_c = upper ? CH_UX : CH_LX;
    end else if (sel_dig) begin
      char_c = digit_char(dig[DIG_W-1 -: 4], upper);
    end else begin
      char_c = CH_SPACE;   // trailing padding
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  logic in_xfer, out_load, norm_shift;

  assign in_xfer    = s_tvalid && s_tready;
  assign norm_shift = (dig[DIG_W-1 -: 4] == 4'd0) && (ndig > 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (in_radix == RADIX_DEC) ? ST_CONV : ST_NORM;
        end
      end
      ST_CONV: begin
        if (bit_cnt == 6'd63) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!norm_shift) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = (rem_c == 7'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        out_load = !m_tvalid || m_tready;
        if (out_load && rem == 7'd1) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag     <= in_mag;
      is_zero <= in_mag == '0;
      neg     <= in_neg;
      radix   <= in_radix;
      upper   <= in_upper;
      alt     <= in_alt;
      left    <= in_left;
      plus    <= in_plus;
      space   <= in_space;
      zpad    <= in_zpad;
      width   <= in_width;
      prec    <= in_prec;
      bit_cnt <= '0;
      ndig    <= 5'(NUM_NIBBLES);
      unique case (in_radix)
        RADIX_OCT: dig <= oct_load;
        RADIX_DEC: dig <= '0;
        default:   dig <= hex_load;
      endcase
    end else if (state == ST_CONV) begin
      dig     <= {dabble[DIG_W-2:0], mag[MAG_W-1]};
      mag     <= {mag[MAG_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + 6'd1;
    end else if (state == ST_NORM) begin
      if (norm_shift) begin
        dig  <= {dig[DIG_W-5:0], 4'h0};
        ndig <= ndig - 5'd1;
      end
    end else if (state == ST_CALC) begin
      ndig      <= ndig_e;
      lpad_cnt  <= left ? 7'd0 : pad9[6:0];
      zero_cnt  <= zeros9[6:0];
      sign_pend <= sign_c;
      pfx0_pend <= pfx_c;
      pfxx_pend <= pfx_c;
      rem       <= rem_c;
    end else if (out_load) begin
      rem <= rem - 7'd1;
      if (sel_lpad) begin
        lpad_cnt <= lpad_cnt - 7'd1;
      end
      if (sel_sign) begin
        sign_pend <= 1'b0;
      end
      if (sel_pfx0) begin
        pfx0_pend <= 1'b0;
      end
      if (sel_pfxx) begin
        pfxx_pend <= 1'b0;
      end
      if (sel_zero) begin
        zero_cnt <= zero_cnt - 7'd1;
      end
      if (sel_dig) begin
        dig  <= {dig[DIG_W-5:0], 4'h0};
        ndig <= ndig - 5'd1;
      end
    end
  end

  // output register: parts the sequencer from the sink
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= char_c;
      m_tlast <= rem == 7'd1;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> (rem != 7'd0 && rem <= 7'(MAX_FIELD)))
    else $error("character count out of range while emitting");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tlast == ($past(rem) == 7'd1)))
    else $error("tlast does not match the final character");

  a_norm_digits: assert property (@(posedge clk) disable iff (rst)
    state == ST_NORM |-> ndig != 5'd0)
    else $error("normalisation dropped every digit");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && state_next == ST_IDLE) |-> (ndig == 5'd0 || !sel_dig || rem == 7'd1))
    else $error("emission ended with digits outstanding");

endmodule
